// ===== rtl/sds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sds_pkg
// Shared types for the saturating signed divider pipeline.
// ----------------------------------------------------------------------------
package sds_pkg;

	// control that travels alongside the data through every stage
	typedef struct packed {
		logic valid;
		logic neg;
		logic dz;
	} sds_ctrl_t;

endpackage : sds_pkg
`default_nettype wire

// ===== rtl/signed_divider_saturating.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_divider_saturating
// Pipelined signed integer divider, quotient truncated toward zero, with
// saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// A request is taken in every cycle that start is high; busy is never raised.
// Each request gives one result on the done strobe after passing through a
// register that forms operand magnitudes, one restoring-division stage per
// quotient bit, and an output register loaded after applying sign, saturation and the
// zero-divisor override. Results come out in request order, one per cycle at
// most, and are shown for a single cycle since the receiver cannot stall.
// Minimum divided by minus one gives the maximum with saturated set; a zero
// divisor gives 0 with div_by_zero set.
module signed_divider_saturating #(
	parameter int DATA_WIDTH = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire  signed [DATA_WIDTH-1:0] dividend,
	input  wire  signed [DATA_WIDTH-1:0] divisor,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output logic                         saturated,
	output logic                         div_by_zero
);
	import sds_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

	logic [W-1:0] a_u;
	logic [W-1:0] b_u;
	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;

	sds_ctrl_t    ctrl_s0;
	logic [W-1:0] dvd_s0;
	logic [W-1:0] dvs_s0;

	sds_ctrl_t    ctrl_p [0:W];
	logic [W-1:0] rem_p  [0:W];
	logic [W-1:0] dvd_p  [0:W];
	logic [W-1:0] dvs_p  [0:W];

	logic [W-1:0] q_mag;
	logic [W-1:0] q_res;
	logic         sat_res;

	logic         done_q;
	logic [W-1:0] quotient_q;
	logic         saturated_q;
	logic         div_by_zero_q;

	assign busy = 1'b0;

	assign a_u   = dividend;
	assign b_u   = divisor;
	assign a_mag = a_u[W-1] ? (~a_u + {{(W-1){1'b0}}, 1'b1}) : a_u;
	assign b_mag = b_u[W-1] ? (~b_u + {{(W-1){1'b0}}, 1'b1}) : b_u;

	// magnitude stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s0 <= '0;
		end else begin
			ctrl_s0.valid <= start;
			ctrl_s0.neg   <= a_u[W-1] ^ b_u[W-1];
			ctrl_s0.dz    <= (b_u == '0);
		end
	end

	always_ff @(posedge clk) begin
		dvd_s0 <= a_mag;
		dvs_s0 <= b_mag;
	end

	assign ctrl_p[0] = ctrl_s0;
	assign rem_p[0]  = '0;
	assign dvd_p[0]  = dvd_s0;
	assign dvs_p[0]  = dvs_s0;

	// one quotient bit per stage, msb first
	for (genvar i = 0; i < W; i++) begin : g_stage
		sds_div_stage #(
			.W(W)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_ctrl (ctrl_p[i]),
			.in_rem  (rem_p[i]),
			.in_dvd  (dvd_p[i]),
			.in_dvs  (dvs_p[i]),
			.out_ctrl(ctrl_p[i+1]),
			.out_rem (rem_p[i+1]),
			.out_dvd (dvd_p[i+1]),
			.out_dvs (dvs_p[i+1])
		);
	end

	assign q_mag = dvd_p[W];

	// magnitude can only reach 2^(W-1), which overflows when positive
	always_comb begin
		q_res   = q_mag;
		sat_res = 1'b0;
		if (ctrl_p[W].dz) begin
			q_res = '0;
		end else if (ctrl_p[W].neg) begin
			q_res = ~q_mag + {{(W-1){1'b0}}, 1'b1};
		end else if (q_mag[W-1]) begin
			q_res   = MAX_VAL;
			sat_res = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_p[W].valid;
		end
	end

	always_ff @(posedge clk) begin
		quotient_q    <= q_res;
		saturated_q   <= sat_res;
		div_by_zero_q <= ctrl_p[W].dz;
	end

	assign done        = done_q;
	assign quotient    = quotient_q;
	assign saturated   = saturated_q;
	assign div_by_zero = div_by_zero_q;

endmodule : signed_divider_saturating
`default_nettype wire

// ===== rtl/sds_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sds_div_stage
// One registered restoring-division step on unsigned magnitudes: develops one
// quotient bit, shifting it into the low end of the dividend word.
// ----------------------------------------------------------------------------
module sds_div_stage #(
	parameter int W = 32
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  sds_pkg::sds_ctrl_t      in_ctrl,
	input  wire  [W-1:0]            in_rem,
	input  wire  [W-1:0]            in_dvd,
	input  wire  [W-1:0]            in_dvs,
	output sds_pkg::sds_ctrl_t      out_ctrl,
	output logic [W-1:0]            out_rem,
	output logic [W-1:0]            out_dvd,
	output logic [W-1:0]            out_dvs
);
	import sds_pkg::*;

	logic [W-1:0] shifted;
	logic [W:0]   diff;
	logic         q_bit;
	logic [W-1:0] rem_next;

	sds_ctrl_t    ctrl_s1;
	logic [W-1:0] rem_s1;
	logic [W-1:0] dvd_s1;
	logic [W-1:0] dvs_s1;

	assign shifted  = {in_rem[W-2:0], in_dvd[W-1]};
	assign diff     = {1'b0, shifted} - {1'b0, in_dvs};
	assign q_bit    = ~diff[W];
	assign rem_next = q_bit ? diff[W-1:0] : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= in_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= rem_next;
		dvd_s1 <= {in_dvd[W-2:0], q_bit};
		dvs_s1 <= in_dvs;
	end

	assign out_ctrl = ctrl_s1;
	assign out_rem  = rem_s1;
	assign out_dvd  = dvd_s1;
	assign out_dvs  = dvs_s1;

endmodule : sds_div_stage
`default_nettype wire

// ===== rtl/sds_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks for the saturating signed divider, bound to the top level.
// ----------------------------------------------------------------------------
module sds_checker #(
	parameter int DATA_WIDTH = 32
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          start,
	input wire                          busy,
	input wire  signed [DATA_WIDTH-1:0] divisor,
	input wire                          done,
	input wire  signed [DATA_WIDTH-1:0] quotient,
	input wire                          saturated,
	input wire                          div_by_zero
);
	localparam int LAT = DATA_WIDTH + 2;
	localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	// every result belongs to a request taken a fixed latency earlier
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	a_zero_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(divisor, LAT) == '0) |-> div_by_zero && !saturated && (quotient == '0))
		else $error("zero divisor not flagged or quotient not cleared");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && saturated |-> (quotient == MAX_VAL) && !div_by_zero
			&& ($past(divisor, LAT) == '1))
		else $error("saturation on wrong operands or wrong clamp value");

	a_flag_needs_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done && div_by_zero |-> ($past(divisor, LAT) == '0))
		else $error("divide-by-zero flagged for a non-zero divisor");

endmodule : sds_checker

bind signed_divider_saturating sds_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sds_checker (.*);
`default_nettype wire

// ===== tb/signed_divider_saturating_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_divider_saturating_tb
// Self-checking bench for the saturating signed divider. Requests go in
// through the start/busy handshake with random gaps and back-to-back
// bursts. Each accepted request is predicted on the spot, and every done
// strobe is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module signed_divider_saturating_tb;

	localparam int DW = 32;
	localparam logic [DW-1:0] INT_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] INT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] ONE     = {{(DW-1){1'b0}}, 1'b1};
	localparam logic [DW-1:0] MINUS1  = {DW{1'b1}};
	localparam logic [DW-1:0] ZERO    = {DW{1'b0}};

	typedef struct packed {
		logic [DW-1:0] quo;
		logic          sat;
		logic          dz;
	} div_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [DW-1:0] dividend = '0;
	logic [DW-1:0] divisor = '0;
	logic          busy;
	logic          done;
	logic [DW-1:0] quotient;
	logic          saturated;
	logic          div_by_zero;

	div_result_t pending_quotients[$];
	int n_errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_zero_div = 0;
	int n_clamped = 0;
	int burst_left = 0;

	signed_divider_saturating #(
		.DATA_WIDTH(DW)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.dividend   (dividend),
		.divisor    (divisor),
		.done       (done),
		.quotient   (quotient),
		.saturated  (saturated),
		.div_by_zero(div_by_zero)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// truncating division on magnitudes, sign applied afterwards
	function automatic div_result_t predict_quotient(input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		div_result_t r;
		logic [DW-1:0] ma;
		logic [DW-1:0] mb;
		logic [DW-1:0] q;
		logic neg;
		r = '0;
		if (b == ZERO) begin
			r.dz = 1'b1;
		end else begin
			ma = a[DW-1] ? (ZERO - a) : a;
			mb = b[DW-1] ? (ZERO - b) : b;
			q = ma / mb;
			neg = a[DW-1] ^ b[DW-1];
			if (neg) begin
				r.quo = ZERO - q;
			end else if (q > INT_MAX) begin
				r.quo = INT_MAX;
				r.sat = 1'b1;
			end else begin
				r.quo = q;
			end
		end
		return r;
	endfunction

	task automatic send_division(input logic [DW-1:0] a, input logic [DW-1:0] b);
		int gap;
		start <= 1'b1;
		dividend <= a;
		divisor <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_quotients.push_back(predict_quotient(a, b));
		n_sent++;
		// mostly random gaps, with occasional back-to-back bursts
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 14);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : check_results
		div_result_t want;
		if (arst_n && done) begin
			if (pending_quotients.size() == 0) begin
				$error("result with no request pending: quotient %h", quotient);
				n_errors++;
			end else begin
				want = pending_quotients.pop_front();
				n_checked++;
				if (want.dz) n_zero_div++;
				if (want.sat) n_clamped++;
				if (quotient !== want.quo) begin
					$error("quotient: expected %h, got %h", want.quo, quotient);
					n_errors++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %b, got %b", want.sat, saturated);
					n_errors++;
				end
				if (div_by_zero !== want.dz) begin
					$error("div_by_zero: expected %b, got %b", want.dz, div_by_zero);
					n_errors++;
				end
			end
		end
	end

	task automatic test_extremes();
		send_division(INT_MAX, ONE);
		send_division(INT_MAX, INT_MAX);
		send_division(INT_MAX, MINUS1);
		send_division(INT_MIN, INT_MIN);
		send_division(INT_MIN, ONE);
		send_division(INT_MIN, INT_MAX);
		send_division(ZERO, INT_MIN);
		send_division(ONE, MINUS1);
		send_division(MINUS1, MINUS1);
		send_division(INT_MAX, INT_MIN);
		send_division(MINUS1, INT_MIN);
		// truncation toward zero on mixed signs
		send_division(32'sd7, -32'sd2);
		send_division(-32'sd7, 32'sd2);
	endtask

	task automatic test_zero_divisor();
		send_division(ZERO, ZERO);
		send_division(INT_MIN, ZERO);
		send_division(INT_MAX, ZERO);
		send_division(MINUS1, ZERO);
		send_division(ONE, ZERO);
	endtask

	task automatic test_overflow();
		send_division(INT_MIN, MINUS1);
		send_division(INT_MIN, -32'sd2);
		send_division(INT_MIN + ONE, MINUS1);
		send_division(INT_MIN, 32'sd2);
	endtask

	function automatic logic [DW-1:0] pick_corner();
		case ($urandom_range(0, 8))
			0: return ZERO;
			1: return ONE;
			2: return MINUS1;
			3: return INT_MIN;
			4: return INT_MAX;
			5: return INT_MIN + ONE;
			6: return 32'sd2;
			7: return -32'sd2;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DW-1:0] small_signed(input int hi);
		logic [DW-1:0] v;
		v = $urandom_range(1, hi);
		return $urandom_range(0, 1) ? (ZERO - v) : v;
	endfunction

	task automatic test_random_operands(input int count);
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		int kind;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				a = $urandom;
				b = $urandom;
			end else if (kind < 60) begin
				// small divisor: large quotients
				a = $urandom;
				b = small_signed(255);
			end else if (kind < 75) begin
				// small dividend over large divisor: quotient zero or tiny
				a = small_signed(1000);
				b = $urandom;
			end else if (kind < 90) begin
				a = pick_corner();
				b = pick_corner();
			end else begin
				// exact multiple
				b = small_signed(65535);
				a = b * small_signed(32767);
			end
			send_division(a, b);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_zero_divisor();
		test_overflow();
		test_random_operands(1250);
		start <= 1'b0;
		while (pending_quotients.size() != 0) @(posedge clk);
		repeat (DW + 8) @(posedge clk);
		$display("covered %0d requests, %0d results checked", n_sent, n_checked);
		$display("zero divisors: %0d, clamped overflows: %0d, errors: %0d",
			n_zero_div, n_clamped, n_errors);
		if (n_errors == 0) begin
			$display("** signed_divider_saturating: PASSED **");
		end else begin
			$display("** signed_divider_saturating: FAILED **");
		end
		$finish;
	end

	initial begin
		#500000;
		$display("timeout with %0d results outstanding", pending_quotients.size());
		$display("** signed_divider_saturating: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sds_pkg.sv
rtl/sds_div_stage.sv
rtl/signed_divider_saturating.sv
rtl/sds_checker.sv
tb/signed_divider_saturating_tb.sv
